### hdl/tlex_pkg.sv
package tlex_pkg;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_NAME   = 4'b0010,
		MODE_NUMBER = 4'b0100,
		MODE_COLON  = 4'b1000
	} mode_t;

	typedef enum logic [4:0] {
		TK_ASSIGN    = 5'd0,
		TK_SEMICOLON = 5'd1,
		TK_COMMA     = 5'd2,
		TK_EQ        = 5'd3,
		TK_ADD       = 5'd4,
		TK_SUB       = 5'd5,
		TK_MUL       = 5'd6,
		TK_DIV       = 5'd7,
		TK_LPAREN    = 5'd8,
		TK_RPAREN    = 5'd9,
		TK_VAR       = 5'd10,
		TK_CONST     = 5'd11,
		TK_WRITE     = 5'd12,
		TK_READ      = 5'd13,
		TK_IDENT     = 5'd14,
		TK_NUMBER    = 5'd15,
		TK_END       = 5'd16,
		TK_UNKNOWN   = 5'd17
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [30:0] value;
		logic        ovf;
		logic [7:0]  len;
		logic [7:0]  bad;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} res_t;

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PTR_W     = 2;
	localparam int unsigned CNT_W     = 3;
	localparam int unsigned PREFIX_BYTES = 6;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// keyword text, first character in the lowest byte
	localparam logic [47:0] KW_VAR_TEXT    = 48'h0000_0072_6176;
	localparam logic [47:0] KW_CONST_TEXT  = 48'h0074_736E_6F63;
	localparam logic [47:0] KW_ECRIRE_TEXT = 48'h6572_6972_6365;
	localparam logic [47:0] KW_LIRE_TEXT   = 48'h0000_6572_696C;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

endpackage

### hdl/token_lexer_with_positions.sv
// Streaming lexer: takes one source byte (or the end marker in tuser) per word and
// emits tokens with their start line and column. A byte is taken in every cycle while
// the four-entry result queue has room for two tokens; a byte that closes a pending
// identifier, number or lone colon and is itself a token, or an end marker after a
// pending token, puts two words on the output, which drains one token per cycle while
// m_axis_tready is high, so such pairs hold the rate below one byte per cycle. Tokens
// are written into the registered result queue and leave behind any already queued.
module token_lexer_with_positions #(
	parameter int unsigned LINE_WIDTH   = 16,
	parameter int unsigned COLUMN_WIDTH = 16,
	parameter int unsigned LENGTH_WIDTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_code
	input  logic        s_axis_tuser,  // end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [87:0] m_axis_tdata,  // token_kind, number_value, value_overflow,
	                                   // name_length, bad_char, token_line, token_column
	output logic        m_axis_tlast   // last_in_run
);

	tlex_pkg::mode_t             mode_q, mode_d;
	logic [47:0]                 prefix_q, prefix_d;
	logic [LENGTH_WIDTH-1:0]     count_q, count_d;
	logic [30:0]                 acc_q, acc_d;
	logic                        ovf_q, ovf_d;
	logic [LINE_WIDTH-1:0]       start_line_q, start_line_d;
	logic [COLUMN_WIDTH-1:0]     start_col_q, start_col_d;
	logic [LINE_WIDTH-1:0]       cur_line_q, cur_line_d;
	logic [COLUMN_WIDTH-1:0]     cur_col_q, cur_col_d;

	tlex_pkg::res_t              fifo_q [tlex_pkg::OUT_DEPTH];
	logic [tlex_pkg::PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [tlex_pkg::CNT_W-1:0]  count_out_q;

	logic [7:0]  c;
	logic        eoi;
	logic        s_fire, m_fire;
	logic        is_ws, is_letter, is_digit;
	logic [COLUMN_WIDTH-1:0] col_inc;
	logic [LINE_WIDTH-1:0]   line_inc;
	logic [LENGTH_WIDTH-1:0] count_inc;
	logic [34:0] acc_sum;
	logic [15:0] start_line_o, start_col_o, cur_line_o, cur_col_o;
	logic [31:0] start_line_w, start_col_w, cur_line_w, cur_col_w;
	logic [15:0] len_w;
	logic [7:0]  len_o;
	tlex_pkg::kind_t kw_kind, op_kind;
	logic        flush_valid;
	tlex_pkg::res_t flush_res, second_res, res0, res1;
	logic        second_valid;
	logic [1:0]  wr_n;

	assign c      = s_axis_tdata;
	assign eoi    = s_axis_tuser;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;

	assign s_axis_tready = (count_out_q <= tlex_pkg::CNT_W'(tlex_pkg::OUT_DEPTH - 2));
	assign m_axis_tvalid = (count_out_q != '0);

	always_comb begin
		is_ws     = (c inside {[8'd9:8'd13]}) || (c == tlex_pkg::CH_SPACE);
		is_letter = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
		is_digit  = (c inside {[8'h30:8'h39]});
	end

	assign col_inc   = (cur_col_q == '1) ? cur_col_q : cur_col_q + 1'b1;
	assign line_inc  = (cur_line_q == '1) ? cur_line_q : cur_line_q + 1'b1;
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

	// acc * 10 + digit, wide enough to see the overflow
	assign acc_sum = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, c[3:0]};

	// positions saturate at 16 bits on the way out
	assign start_line_w = 32'(start_line_q);
	assign start_col_w  = 32'(start_col_q);
	assign cur_line_w   = 32'(cur_line_q);
	assign cur_col_w    = 32'(cur_col_q);
	assign start_line_o = (start_line_w > 32'h0000_FFFF) ? 16'hFFFF : start_line_w[15:0];
	assign start_col_o  = (start_col_w > 32'h0000_FFFF) ? 16'hFFFF : start_col_w[15:0];
	assign cur_line_o   = (cur_line_w > 32'h0000_FFFF) ? 16'hFFFF : cur_line_w[15:0];
	assign cur_col_o    = (cur_col_w > 32'h0000_FFFF) ? 16'hFFFF : cur_col_w[15:0];
	assign len_w        = 16'(count_q);
	assign len_o        = (len_w > 16'd255) ? 8'hFF : len_w[7:0];

	always_comb begin
		if (count_q == LENGTH_WIDTH'(3) && prefix_q == tlex_pkg::KW_VAR_TEXT)
			kw_kind = tlex_pkg::TK_VAR;
		else if (count_q == LENGTH_WIDTH'(5) && prefix_q == tlex_pkg::KW_CONST_TEXT)
			kw_kind = tlex_pkg::TK_CONST;
		else if (count_q == LENGTH_WIDTH'(6) && prefix_q == tlex_pkg::KW_ECRIRE_TEXT)
			kw_kind = tlex_pkg::TK_WRITE;
		else if (count_q == LENGTH_WIDTH'(4) && prefix_q == tlex_pkg::KW_LIRE_TEXT)
			kw_kind = tlex_pkg::TK_READ;
		else
			kw_kind = tlex_pkg::TK_IDENT;
	end

	always_comb begin
		case (c)
			tlex_pkg::CH_SEMI:   op_kind = tlex_pkg::TK_SEMICOLON;
			tlex_pkg::CH_COMMA:  op_kind = tlex_pkg::TK_COMMA;
			tlex_pkg::CH_EQ:     op_kind = tlex_pkg::TK_EQ;
			tlex_pkg::CH_PLUS:   op_kind = tlex_pkg::TK_ADD;
			tlex_pkg::CH_MINUS:  op_kind = tlex_pkg::TK_SUB;
			tlex_pkg::CH_STAR:   op_kind = tlex_pkg::TK_MUL;
			tlex_pkg::CH_SLASH:  op_kind = tlex_pkg::TK_DIV;
			tlex_pkg::CH_LPAREN: op_kind = tlex_pkg::TK_LPAREN;
			tlex_pkg::CH_RPAREN: op_kind = tlex_pkg::TK_RPAREN;
			default:             op_kind = tlex_pkg::TK_UNKNOWN;
		endcase
	end

	// token closed by the pending scan, if any
	always_comb begin
		flush_res = '0;
		flush_res.line = start_line_o;
		flush_res.col  = start_col_o;
		case (mode_q)
			tlex_pkg::MODE_NAME: begin
				// keywords only count with whitespace right behind them
				flush_res.kind = (!eoi && is_ws) ? kw_kind : tlex_pkg::TK_IDENT;
				flush_res.len  = (flush_res.kind == tlex_pkg::TK_IDENT) ? len_o : 8'd0;
			end
			tlex_pkg::MODE_NUMBER: begin
				flush_res.kind  = tlex_pkg::TK_NUMBER;
				flush_res.value = acc_q;
				flush_res.ovf   = ovf_q;
			end
			tlex_pkg::MODE_COLON: begin
				flush_res.kind = tlex_pkg::TK_UNKNOWN;
				flush_res.bad  = tlex_pkg::CH_COLON;
			end
			default: flush_res.kind = tlex_pkg::TK_IDENT;
		endcase
	end

	always_comb begin
		mode_d       = mode_q;
		prefix_d     = prefix_q;
		count_d      = count_q;
		acc_d        = acc_q;
		ovf_d        = ovf_q;
		start_line_d = start_line_q;
		start_col_d  = start_col_q;
		cur_line_d   = cur_line_q;
		cur_col_d    = cur_col_q;
		flush_valid  = 1'b0;
		second_valid = 1'b0;
		second_res   = '0;
		second_res.line = cur_line_o;
		second_res.col  = cur_col_o;

		if (s_fire) begin
			if (eoi) begin
				flush_valid     = (mode_q != tlex_pkg::MODE_IDLE);
				second_valid    = 1'b1;
				second_res.kind = tlex_pkg::TK_END;
				mode_d       = tlex_pkg::MODE_IDLE;
				prefix_d     = '0;
				count_d      = '0;
				acc_d        = '0;
				ovf_d        = 1'b0;
				start_line_d = LINE_WIDTH'(1);
				start_col_d  = COLUMN_WIDTH'(1);
				cur_line_d   = LINE_WIDTH'(1);
				cur_col_d    = COLUMN_WIDTH'(1);
			end else if (mode_q == tlex_pkg::MODE_COLON && c == tlex_pkg::CH_EQ) begin
				second_valid    = 1'b1;
				second_res.kind = tlex_pkg::TK_ASSIGN;
				second_res.line = start_line_o;
				second_res.col  = start_col_o;
				mode_d    = tlex_pkg::MODE_IDLE;
				cur_col_d = col_inc;
			end else if (mode_q == tlex_pkg::MODE_NAME && (is_letter || is_digit)) begin
				for (int i = 0; i < tlex_pkg::PREFIX_BYTES; i++) begin
					if (count_q == LENGTH_WIDTH'(i))
						prefix_d[8*i +: 8] = c;
				end
				count_d   = count_inc;
				cur_col_d = col_inc;
			end else if (mode_q == tlex_pkg::MODE_NUMBER && is_digit) begin
				if (|acc_sum[34:31]) begin
					acc_d = tlex_pkg::NUM_MAX;
					ovf_d = 1'b1;
				end else begin
					acc_d = acc_sum[30:0];
				end
				cur_col_d = col_inc;
			end else begin
				flush_valid = (mode_q != tlex_pkg::MODE_IDLE);
				mode_d      = tlex_pkg::MODE_IDLE;
				if (is_ws) begin
					if (c == tlex_pkg::CH_NL) begin
						cur_line_d = line_inc;
						cur_col_d  = COLUMN_WIDTH'(1);
					end else begin
						cur_col_d = col_inc;
					end
				end else if (is_letter) begin
					mode_d       = tlex_pkg::MODE_NAME;
					start_line_d = cur_line_q;
					start_col_d  = cur_col_q;
					prefix_d     = {40'd0, c};
					count_d      = LENGTH_WIDTH'(1);
					cur_col_d    = col_inc;
				end else if (is_digit) begin
					mode_d       = tlex_pkg::MODE_NUMBER;
					start_line_d = cur_line_q;
					start_col_d  = cur_col_q;
					acc_d        = {27'd0, c[3:0]};
					ovf_d        = 1'b0;
					cur_col_d    = col_inc;
				end else if (c == tlex_pkg::CH_COLON) begin
					mode_d       = tlex_pkg::MODE_COLON;
					start_line_d = cur_line_q;
					start_col_d  = cur_col_q;
					cur_col_d    = col_inc;
				end else begin
					second_valid    = 1'b1;
					second_res.kind = op_kind;
					second_res.bad  = (op_kind == tlex_pkg::TK_UNKNOWN) ? c : 8'd0;
					cur_col_d       = col_inc;
				end
			end
		end
	end

	always_comb begin
		res0 = flush_valid ? flush_res : second_res;
		res1 = second_res;
		res0.last = !(flush_valid && second_valid);
		res1.last = 1'b1;
		wr_n = {1'b0, flush_valid} + {1'b0, second_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= tlex_pkg::MODE_IDLE;
			prefix_q     <= '0;
			count_q      <= '0;
			acc_q        <= '0;
			ovf_q        <= 1'b0;
			start_line_q <= LINE_WIDTH'(1);
			start_col_q  <= COLUMN_WIDTH'(1);
			cur_line_q   <= LINE_WIDTH'(1);
			cur_col_q    <= COLUMN_WIDTH'(1);
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_out_q  <= '0;
		end else begin
			mode_q       <= mode_d;
			prefix_q     <= prefix_d;
			count_q      <= count_d;
			acc_q        <= acc_d;
			ovf_q        <= ovf_d;
			start_line_q <= start_line_d;
			start_col_q  <= start_col_d;
			cur_line_q   <= cur_line_d;
			cur_col_q    <= cur_col_d;
			wr_ptr_q     <= wr_ptr_q + tlex_pkg::PTR_W'(wr_n);
			if (m_fire)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_out_q  <= count_out_q + tlex_pkg::CNT_W'(wr_n)
			                - tlex_pkg::CNT_W'(m_fire);
		end
	end

	// result queue payload
	always_ff @(posedge clk) begin
		if (wr_n != 2'd0)
			fifo_q[wr_ptr_q] <= res0;
		if (wr_n == 2'd2)
			fifo_q[wr_ptr_q + 1'b1] <= res1;
	end

	tlex_pkg::res_t head;
	assign head = fifo_q[rd_ptr_q];

	assign m_axis_tdata = {3'b000, head.col, head.line, head.bad, head.len,
	                       head.ovf, head.value, head.kind};
	assign m_axis_tlast = head.last;

	// queue never overfills: ready leaves room for two words
	assert property (@(posedge clk) disable iff (!arst_n)
		count_out_q <= tlex_pkg::CNT_W'(tlex_pkg::OUT_DEPTH))
		else $error("result queue overflow");

	// end marker always yields at least the end token
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && eoi |=> count_out_q != '0)
		else $error("end marker produced no token");

	// end marker returns the lexer to its start position
	assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && eoi |=> mode_q == tlex_pkg::MODE_IDLE
			&& cur_line_q == LINE_WIDTH'(1) && cur_col_q == COLUMN_WIDTH'(1))
		else $error("state not restored after end marker");

	// an identifier in progress has at least one character
	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == tlex_pkg::MODE_NAME |-> count_q != '0)
		else $error("empty identifier scan");

endmodule
